>>> src/lcot_pkg.sv
package lcot_pkg;

    // Link and data state codes
    localparam logic [1:0] ST_LOCKED   = 2'd0;
    localparam logic [1:0] ST_NOBASIS  = 2'd1;
    localparam logic [1:0] ST_DEGRADED = 2'd2;
    localparam logic [1:0] ST_SIM      = 2'd3;

    // Event kinds carried in tuser
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_DATA = 2'd1;

    // Configuration register indexes
    localparam logic [2:0] CFG_BASIS_LOST   = 3'd0;
    localparam logic [2:0] CFG_DEGRADE      = 3'd1;
    localparam logic [2:0] CFG_SIM_FALLBACK = 3'd2;
    localparam logic [2:0] CFG_EPOCH_JUMP   = 3'd3;
    localparam logic [2:0] CFG_ALPHA_SHIFT  = 3'd4;

    // Register reset values
    localparam logic [15:0] RST_BASIS_LOST   = 16'd60;
    localparam logic [15:0] RST_DEGRADE      = 16'd500;
    localparam logic [15:0] RST_SIM_FALLBACK = 16'd3000;
    localparam logic [15:0] RST_EPOCH_JUMP   = 16'd1000;
    localparam logic [3:0]  RST_ALPHA_SHIFT  = 4'd3;

    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    typedef logic [1:0] t_lstate;

    typedef struct packed {
        logic [15:0] basis_lost;
        logic [15:0] degrade;
        logic [15:0] sim_fallback;
    } t_thresh;

    // Classify an event age against the thresholds
    function automatic t_lstate classify(input logic [31:0] age, input logic seen,
                                         input t_thresh th);
        t_lstate st;
        if (!seen)                           st = ST_SIM;
        else if (age > {16'd0, th.sim_fallback}) st = ST_SIM;
        else if (age > {16'd0, th.degrade})  st = ST_DEGRADED;
        else if (age > {16'd0, th.basis_lost}) st = ST_NOBASIS;
        else                                 st = ST_LOCKED;
        return st;
    endfunction

endpackage

>>> src/lcot_ram.sv
module lcot_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry with a registered output
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/link_clock_offset_tracker.sv
// A tick is sequenced through the window scan, the filter update and the
// state refresh; a data arrival or a time update goes to the state refresh
// only. The window scan reads one sample memory entry per cycle. The block
// takes one item at a time; the next item is accepted once the result is
// in the output register. Reset (synchronous, active low) restores the register
// defaults, empties the window and sets both states to sim fallback.
module link_clock_offset_tracker
    import lcot_pkg::*;
#(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration write port
    input  logic          i_cfg_wr_en,
    input  logic [2:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    // input events
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // [31:0] host_ms, [63:32] peer_stamp_ms, [71:64] peer_seq
    input  logic [71:0]   i_s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]    i_s_axis_tuser,
    // results
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // [1:0] link_state, [3:2] data_state, [35:4] master_now_ms, [67:36] offset_ms,
    // [68] offset_valid, [84:69] seq_gap_count, [100:85] seq_missing_count,
    // [116:101] tick_count, [119:117] zero
    output logic [119:0]  o_m_axis_tdata
);

    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam logic [FW-1:0] FILL_FULL = FW'(WINDOW_DEPTH);
    localparam logic [AW-1:0] HEAD_LAST = AW'(WINDOW_DEPTH - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_DIFF    = 3'd2;
    localparam logic [2:0] S_UPD     = 3'd3;
    localparam logic [2:0] S_REFRESH = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    // Configuration registers
    t_thresh      r_thresh;
    logic [15:0]  r_epoch_jump;
    logic [3:0]   r_alpha_shift;

    // Control and tracking state
    logic [2:0]   r_state;
    logic [FW-1:0] r_fill;
    logic [AW-1:0] r_head;
    logic [31:0]  r_est;
    logic         r_have_est;
    t_lstate      r_tick_state;
    t_lstate      r_data_state;
    logic [7:0]   r_last_seq;
    logic         r_have_seq;
    logic [15:0]  r_gap_cnt;
    logic [15:0]  r_miss_cnt;
    logic [15:0]  r_tick_cnt;
    logic [31:0]  r_last_tick;
    logic [31:0]  r_last_data;
    logic         r_seen_tick;
    logic         r_seen_data;
    logic [31:0]  r_cur_time;

    // Scan and filter datapath
    logic [FW-1:0] r_idx;
    logic         r_pend;
    logic         r_min_ok;
    logic [31:0]  r_min;
    logic         r_neg;
    logic [32:0]  r_mag;

    // Output register
    logic         r_out_valid;
    logic [119:0] r_out_data;

    logic         accept;
    logic [31:0]  in_local;
    logic [31:0]  in_stamp;
    logic [7:0]   in_seq;
    logic [7:0]   seq_step;
    logic         ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]  ram_wdata;
    logic [31:0]  ram_rdata;
    logic [33:0]  half;
    logic [33:0]  rounded;
    logic [31:0]  n_est;
    t_lstate      n_tick_state;
    t_lstate      n_data_state;
    logic [31:0]  master;

    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign in_local = i_s_axis_tdata[31:0];
    assign in_stamp = i_s_axis_tdata[63:32];
    assign in_seq   = i_s_axis_tdata[71:64];
    assign seq_step = in_seq - r_last_seq;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Push the new sample at accept: fill the window first, then overwrite oldest
    assign ram_we    = accept && (i_s_axis_tuser == REQ_TICK);
    assign ram_waddr = (r_fill < FILL_FULL) ? r_fill[AW-1:0] : r_head;
    assign ram_wdata = in_stamp - in_local;

    lcot_ram #(
        .WIDTH (32),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Low-pass step: rounded shift of the magnitude, half away from zero
    always_comb begin
        half = (r_alpha_shift != 4'd0) ? (34'd1 << (r_alpha_shift - 4'd1)) : 34'd0;
        rounded = ({1'b0, r_mag} + half) >> r_alpha_shift;
        if (!r_have_est) begin
            n_est = r_min;
        end else if ((r_tick_state != ST_LOCKED) && (r_mag > {17'd0, r_epoch_jump})) begin
            n_est = r_min;
        end else if (r_neg) begin
            n_est = r_est - rounded[31:0];
        end else begin
            n_est = r_est + rounded[31:0];
        end
    end

    // Classify both ages against the current time
    assign n_tick_state = classify(r_cur_time - r_last_tick, r_seen_tick, r_thresh);
    assign n_data_state = classify(r_cur_time - r_last_data, r_seen_data, r_thresh);

    assign master = ((r_tick_state == ST_LOCKED) && r_have_est) ? r_cur_time + r_est
                                                                 : r_cur_time;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh.basis_lost   <= RST_BASIS_LOST;
            r_thresh.degrade      <= RST_DEGRADE;
            r_thresh.sim_fallback <= RST_SIM_FALLBACK;
            r_epoch_jump          <= RST_EPOCH_JUMP;
            r_alpha_shift         <= RST_ALPHA_SHIFT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_BASIS_LOST:   r_thresh.basis_lost   <= i_cfg_data;
                CFG_DEGRADE:      r_thresh.degrade      <= i_cfg_data;
                CFG_SIM_FALLBACK: r_thresh.sim_fallback <= i_cfg_data;
                CFG_EPOCH_JUMP:   r_epoch_jump          <= i_cfg_data;
                CFG_ALPHA_SHIFT:  r_alpha_shift         <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Sequence the event through scan, filter update and state refresh
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fill       <= '0;
            r_head       <= '0;
            r_est        <= '0;
            r_have_est   <= 1'b0;
            r_tick_state <= ST_SIM;
            r_data_state <= ST_SIM;
            r_last_seq   <= '0;
            r_have_seq   <= 1'b0;
            r_gap_cnt    <= '0;
            r_miss_cnt   <= '0;
            r_tick_cnt   <= '0;
            r_last_tick  <= '0;
            r_last_data  <= '0;
            r_seen_tick  <= 1'b0;
            r_seen_data  <= 1'b0;
            r_cur_time   <= '0;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // load the result when the sequencer is done, drop it once taken
            if ((r_state == S_DONE) && (!r_out_valid || i_m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cur_time <= in_local;
                        r_idx      <= '0;
                        r_pend     <= 1'b0;
                        r_min_ok   <= 1'b0;
                        if (i_s_axis_tuser == REQ_TICK) begin
                            // count gaps and missing frames
                            if (r_have_seq && (seq_step != 8'd1)) begin
                                r_gap_cnt <= r_gap_cnt + 16'd1;
                                if (seq_step > 8'd1) begin
                                    r_miss_cnt <= r_miss_cnt + {8'd0, seq_step} - 16'd1;
                                end
                            end
                            r_have_seq  <= 1'b1;
                            r_last_seq  <= in_seq;
                            if (r_tick_cnt != CNT_MAX) begin
                                r_tick_cnt <= r_tick_cnt + 16'd1;
                            end
                            r_last_tick <= in_local;
                            r_seen_tick <= 1'b1;
                            // advance fill or head after the push
                            if (r_fill < FILL_FULL) begin
                                r_fill <= r_fill + FW'(1);
                            end else if (r_head == HEAD_LAST) begin
                                r_head <= '0;
                            end else begin
                                r_head <= r_head + AW'(1);
                            end
                            r_state <= S_SCAN;
                        end else begin
                            if (i_s_axis_tuser == REQ_DATA) begin
                                r_last_data <= in_local;
                                r_seen_data <= 1'b1;
                            end
                            r_state <= S_REFRESH;
                        end
                    end
                end

                S_SCAN: begin
                    // issue one read a cycle, compare its data in the next cycle
                    if (r_idx < r_fill) begin
                        r_idx  <= r_idx + FW'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend) begin
                        r_min_ok <= 1'b1;
                        if (!r_min_ok || ($signed(ram_rdata) < $signed(r_min))) begin
                            r_min <= ram_rdata;
                        end
                    end else if (r_idx >= r_fill) begin
                        r_state <= S_DIFF;
                    end
                end

                S_DIFF: begin
                    if ($signed(r_min) < $signed(r_est)) begin
                        r_neg <= 1'b1;
                        r_mag <= {r_est[31], r_est} - {r_min[31], r_min};
                    end else begin
                        r_neg <= 1'b0;
                        r_mag <= {r_min[31], r_min} - {r_est[31], r_est};
                    end
                    r_state <= S_UPD;
                end

                S_UPD: begin
                    r_est      <= n_est;
                    r_have_est <= 1'b1;
                    r_state    <= S_REFRESH;
                end

                S_REFRESH: begin
                    r_tick_state <= n_tick_state;
                    r_data_state <= n_data_state;
                    // on a change of link state to any state but locked, empty the window
                    if (n_tick_state != r_tick_state) begin
                        if (n_tick_state == ST_SIM) begin
                            r_fill     <= '0;
                            r_head     <= '0;
                            r_have_est <= 1'b0;
                        end else if (n_tick_state inside {ST_NOBASIS, ST_DEGRADED}) begin
                            r_fill <= '0;
                            r_head <= '0;
                        end
                    end
                    r_state <= S_DONE;
                end

                S_DONE: begin
                    // leave once the output register is free
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Assemble the result item
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && (!r_out_valid || i_m_axis_tready)) begin
            r_out_data <= {3'd0, r_tick_cnt, r_miss_cnt, r_gap_cnt, r_have_est,
                           (r_have_est ? r_est : 32'd0), master,
                           r_data_state, r_tick_state};
        end
    end

`ifndef SYNTHESIS
    // window never holds more samples than it has entries
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("window fill above depth");

    // one item at a time: no accept in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("item accepted while busy");

    // outside lock the window stays empty between items
    a_empty_unlocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && (r_tick_state != ST_LOCKED)) |-> (r_fill == '0))
        else $error("window holds samples while not locked");

    // a result without an estimate carries a zero offset
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[68]) |-> (o_m_axis_tdata[67:36] == 32'd0))
        else $error("offset reported without estimate");
`endif

endmodule

>>> tb/sv/link_clock_offset_tracker_tb.sv
`timescale 1ns / 1ps

module link_clock_offset_tracker_tb;
    import lcot_pkg::*;

    localparam int WIN_DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 165;
    localparam int NUM_PHASES = 6;
    localparam int DIR_COUNT = 22;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 30;

    // Kinds beyond the package pair: plain time update, and the spare code handled as one
    localparam logic [1:0] REQ_UPDATE     = 2'd2;
    localparam logic [1:0] REQ_UPDATE_ALT = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] host_ms;
        logic [31:0] stamp;
        logic [7:0]  seq;
    } t_event;

    typedef struct packed {
        logic [1:0]  link;
        logic [1:0]  data;
        logic [31:0] master;
        logic [31:0] offset;
        logic        valid;
        logic [15:0] gaps;
        logic [15:0] missing;
        logic [15:0] ticks;
    } t_result;

    typedef struct packed {
        t_event  ev;
        logic    typed;
        t_result res;
    } t_row;

    localparam t_result NO_RES = '0;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_wr_en = 1'b0;
    logic [2:0]    i_cfg_index = '0;
    logic [15:0]   i_cfg_data = '0;
    logic          i_s_axis_tvalid = 1'b0;
    logic          o_s_axis_tready;
    // [31:0] host_ms, [63:32] peer_stamp_ms, [71:64] peer_seq
    logic [71:0]   i_s_axis_tdata = '0;
    // [1:0] req_type
    logic [1:0]    i_s_axis_tuser = '0;
    logic          o_m_axis_tvalid;
    logic          i_m_axis_tready = 1'b0;
    // [1:0] link_state, [3:2] data_state, [35:4] master_now_ms, [67:36] offset_ms,
    // [68] offset_valid, [84:69] seq_gap_count, [100:85] seq_missing_count,
    // [116:101] tick_count, [119:117] zero
    logic [119:0]  o_m_axis_tdata;

    link_clock_offset_tracker #(
        .WINDOW_DEPTH(WIN_DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    // Clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Tracker copy: configuration
    logic [15:0] cfg_basis_ms, cfg_degrade_ms, cfg_sim_ms, cfg_epoch_ms;
    logic [3:0]  cfg_gain_shift;

    // Tracker copy: state
    logic [31:0] win_samples [WIN_DEPTH];
    int          win_fill, win_head;
    logic [31:0] est_offset;
    logic        est_held;
    logic [1:0]  link_st, data_st;
    logic [7:0]  prev_seq;
    logic        seq_seen;
    logic [15:0] gap_cnt, miss_cnt, tick_cnt;
    logic [31:0] last_tick_ms, last_data_ms, now_ms;
    logic        tick_seen, data_seen;

    t_result pending_results [$];
    int   err_count = 0;
    int   cycle_count = 0;
    int   burst_left;
    bit   long_hold_req = 0;
    bit   long_hold_done = 0;

    // Link model driving the random part
    logic [31:0] sim_local, sim_off;
    logic [7:0]  sim_seq;

    t_row dir_rows [DIR_COUNT];

    // Classify an age against the current thresholds
    function automatic logic [1:0] age_state(input logic [31:0] age, input logic seen);
        if (!seen) return ST_SIM;
        if (age > cfg_sim_ms) return ST_SIM;
        if (age > cfg_degrade_ms) return ST_DEGRADED;
        if (age > cfg_basis_ms) return ST_NOBASIS;
        return ST_LOCKED;
    endfunction

    // Shift right by sh, rounding half away from zero
    function automatic longint shift_round(input longint d, input int sh);
        longint half;
        half = (sh != 0) ? (longint'(1) <<< (sh - 1)) : 0;
        if (d >= 0) return (d + half) >>> sh;
        return -(((-d) + half) >>> sh);
    endfunction

    // Advance the tracker copy by one item and form its result
    task automatic predict_tracker(input t_event ev, output t_result r);
        logic [7:0] step;
        logic [1:0] prev_link;
        bit         was_locked;
        longint     mn, off, diff, v;
        case (ev.kind)
            REQ_TICK: begin
                was_locked = (link_st == ST_LOCKED);
                if (seq_seen) begin
                    step = ev.seq - prev_seq;
                    if (step != 8'd1) begin
                        gap_cnt = gap_cnt + 16'd1;
                        if (step > 8'd1) miss_cnt = miss_cnt + {8'd0, step} - 16'd1;
                    end
                end
                seq_seen = 1'b1;
                prev_seq = ev.seq;
                if (tick_cnt != CNT_MAX) tick_cnt = tick_cnt + 16'd1;
                last_tick_ms = ev.host_ms;
                tick_seen = 1'b1;
                now_ms = ev.host_ms;
                // push the sample, overwriting the oldest once full
                if (win_fill < WIN_DEPTH) begin
                    win_samples[win_fill] = ev.stamp - ev.host_ms;
                    win_fill++;
                end else begin
                    win_samples[win_head] = ev.stamp - ev.host_ms;
                    win_head = (win_head + 1) % WIN_DEPTH;
                end
                mn = longint'($signed(win_samples[0]));
                for (int i = 1; i < win_fill; i++) begin
                    v = longint'($signed(win_samples[i]));
                    if (v < mn) mn = v;
                end
                off = longint'($signed(est_offset));
                diff = mn - off;
                if (!est_held) begin
                    est_offset = mn[31:0];
                    est_held = 1'b1;
                end else if (!was_locked && (diff > longint'(cfg_epoch_ms) ||
                                             -diff > longint'(cfg_epoch_ms))) begin
                    est_offset = mn[31:0];
                end else begin
                    v = off + shift_round(diff, int'(cfg_gain_shift));
                    est_offset = v[31:0];
                end
            end
            REQ_DATA: begin
                last_data_ms = ev.host_ms;
                data_seen = 1'b1;
                now_ms = ev.host_ms;
            end
            default: begin
                now_ms = ev.host_ms;
            end
        endcase
        // reclassify; leaving lock empties the window, falling back drops the estimate
        prev_link = link_st;
        link_st = age_state(now_ms - last_tick_ms, tick_seen);
        data_st = age_state(now_ms - last_data_ms, data_seen);
        if (prev_link != link_st) begin
            if (link_st == ST_SIM) begin
                win_fill = 0;
                win_head = 0;
                est_held = 1'b0;
            end else if (link_st == ST_NOBASIS || link_st == ST_DEGRADED) begin
                win_fill = 0;
                win_head = 0;
            end
        end
        r.link    = link_st;
        r.data    = data_st;
        r.master  = (link_st == ST_LOCKED && est_held) ? now_ms + est_offset : now_ms;
        r.offset  = est_held ? est_offset : 32'd0;
        r.valid   = est_held;
        r.gaps    = gap_cnt;
        r.missing = miss_cnt;
        r.ticks   = tick_cnt;
    endtask

    // Offer one item, predict at acceptance, then maybe pause between bursts
    task automatic send_event(input t_event ev, input logic typed, input t_result typed_res);
        t_result r;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {ev.seq, ev.stamp, ev.host_ms};
        i_s_axis_tuser  <= ev.kind;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_tracker(ev, r);
        pending_results.push_back(typed ? typed_res : r);
        burst_left--;
        if (burst_left <= 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    // Write one register and mirror it
    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_BASIS_LOST:   cfg_basis_ms = val;
            CFG_DEGRADE:      cfg_degrade_ms = val;
            CFG_SIM_FALLBACK: cfg_sim_ms = val;
            CFG_EPOCH_JUMP:   cfg_epoch_ms = val;
            CFG_ALPHA_SHIFT:  cfg_gain_shift = val[3:0];
            default: ;
        endcase
    endtask

    // Drain the block before touching the registers
    task automatic wait_idle();
        if (i_s_axis_tvalid) i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (WIN_DEPTH + 9) @(posedge i_clk);
    endtask

    task automatic apply_phase_config(input int phase);
        logic [15:0] b, d, s, e;
        logic [3:0]  g;
        case (phase)
            1: begin
                b = 16'd0; d = 16'd0; s = 16'd0; e = 16'd0; g = 4'd0;
            end
            2: begin
                b = 16'hFFFF; d = 16'hFFFF; s = 16'hFFFF; e = 16'hFFFF; g = 4'd15;
            end
            3: begin
                b = 16'($urandom_range(20, 100));
                d = 16'($urandom_range(200, 800));
                s = 16'($urandom_range(1000, 5000));
                e = 16'($urandom_range(0, 2000));
                g = 4'd1;
            end
            4: begin
                b = 16'($urandom_range(0, 65535));
                d = 16'($urandom_range(0, 65535));
                s = 16'($urandom_range(0, 65535));
                e = 16'($urandom_range(0, 65535));
                g = 4'($urandom_range(0, 15));
            end
            default: begin
                b = RST_BASIS_LOST; d = RST_DEGRADE; s = RST_SIM_FALLBACK;
                e = RST_EPOCH_JUMP; g = RST_ALPHA_SHIFT;
            end
        endcase
        cfg_write(CFG_BASIS_LOST, b);
        cfg_write(CFG_DEGRADE, d);
        cfg_write(CFG_SIM_FALLBACK, s);
        cfg_write(CFG_EPOCH_JUMP, e);
        cfg_write(CFG_ALPHA_SHIFT, {12'd0, g});
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly a well-behaved link with random timing, plus jumps and raw noise
    task automatic gen_link_event(output t_event ev);
        int unsigned r, bl;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            ev.kind = 2'($urandom_range(0, 3));
            ev.host_ms = $urandom;
            ev.stamp = $urandom;
            ev.seq = 8'($urandom_range(0, 255));
            sim_local = ev.host_ms;
            if (ev.kind == REQ_TICK) sim_seq = ev.seq;
            return;
        end
        // advance time, now and then past each threshold
        bl = cfg_basis_ms;
        r = $urandom_range(0, 99);
        if (r < 75)      sim_local = sim_local + $urandom_range(0, bl + bl / 2 + 5);
        else if (r < 90) sim_local = sim_local + $urandom_range(0, int'(cfg_degrade_ms) + 200);
        else if (r < 97) sim_local = sim_local + $urandom_range(0, int'(cfg_sim_ms) + 500);
        else             sim_local = sim_local + $urandom;
        ev.host_ms = sim_local;
        ev.stamp = $urandom;
        ev.seq = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 55) begin
            ev.kind = REQ_TICK;
            r = $urandom_range(0, 99);
            if (r < 88)      sim_seq = sim_seq + 8'd1;
            else if (r < 95) sim_seq = 8'($urandom_range(0, 255));
            ev.seq = sim_seq;
            if ($urandom_range(0, 99) < 4) sim_off = $urandom;
            ev.stamp = sim_local + sim_off + $urandom_range(0, 30);
        end else if (r < 80) begin
            ev.kind = REQ_DATA;
        end else if (r < 90) begin
            ev.kind = REQ_UPDATE;
        end else begin
            ev.kind = REQ_UPDATE_ALT;
        end
    endtask

    function automatic void check_field(input string name, input longint unsigned exp_v,
                                        input longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            err_count++;
        end
    endfunction

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result item with no expectation: %0h", o_m_axis_tdata);
                err_count++;
            end else begin
                exp_r = pending_results.pop_front();
                check_field("link_state", exp_r.link, o_m_axis_tdata[1:0]);
                check_field("data_state", exp_r.data, o_m_axis_tdata[3:2]);
                check_field("master_now_ms", exp_r.master, o_m_axis_tdata[35:4]);
                check_field("offset_ms", exp_r.offset, o_m_axis_tdata[67:36]);
                check_field("offset_valid", exp_r.valid, o_m_axis_tdata[68]);
                check_field("seq_gap_count", exp_r.gaps, o_m_axis_tdata[84:69]);
                check_field("seq_missing_count", exp_r.missing, o_m_axis_tdata[100:85]);
                check_field("tick_count", exp_r.ticks, o_m_axis_tdata[116:101]);
            end
        end
    end

    // Receiver: runs and stalls of random length, one long hold-off on request
    initial begin
        int run_left, stall_left, hold_left;
        bit rdy;
        run_left = 0;
        stall_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
                if (hold_left == 0) long_hold_done = 1'b1;
            end else if (long_hold_req && !long_hold_done) begin
                hold_left = LONG_HOLD_CYCLES;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                rdy = 1'b1;
            end else begin
                if ($urandom_range(0, 7) == 0) begin
                    run_left = 200;
                    stall_left = 0;
                end else begin
                    run_left = $urandom_range(1, 30);
                    stall_left = $urandom_range(1, 12);
                end
                rdy = 1'b1;
            end
            i_m_axis_tready <= rdy;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus
    initial begin
        t_event ev;
        // directed rows: fresh link, sequence wrap and gaps, state decay, relock, extremes
        dir_rows = '{
            '{'{REQ_UPDATE, 32'd0, 32'd0, 8'd0}, 1'b1,
              '{ST_SIM, ST_SIM, 32'd0, 32'd0, 1'b0, 16'd0, 16'd0, 16'd0}},
            '{'{REQ_TICK, 32'd100, 32'd150, 8'd255}, 1'b1,
              '{ST_LOCKED, ST_SIM, 32'd150, 32'd50, 1'b1, 16'd0, 16'd0, 16'd1}},
            '{'{REQ_TICK, 32'd110, 32'd160, 8'd0}, 1'b1,
              '{ST_LOCKED, ST_SIM, 32'd160, 32'd50, 1'b1, 16'd0, 16'd0, 16'd2}},
            '{'{REQ_TICK, 32'd120, 32'd170, 8'd0}, 1'b1,
              '{ST_LOCKED, ST_SIM, 32'd170, 32'd50, 1'b1, 16'd1, 16'd0, 16'd3}},
            '{'{REQ_TICK, 32'd130, 32'd180, 8'd5}, 1'b1,
              '{ST_LOCKED, ST_SIM, 32'd180, 32'd50, 1'b1, 16'd2, 16'd4, 16'd4}},
            '{'{REQ_DATA, 32'd140, 32'd0, 8'd0}, 1'b1,
              '{ST_LOCKED, ST_LOCKED, 32'd190, 32'd50, 1'b1, 16'd2, 16'd4, 16'd4}},
            '{'{REQ_UPDATE_ALT, 32'd141, 32'd0, 8'd0}, 1'b1,
              '{ST_LOCKED, ST_LOCKED, 32'd191, 32'd50, 1'b1, 16'd2, 16'd4, 16'd4}},
            '{'{REQ_UPDATE, 32'd200, 32'd0, 8'd0}, 1'b1,
              '{ST_NOBASIS, ST_LOCKED, 32'd200, 32'd50, 1'b1, 16'd2, 16'd4, 16'd4}},
            '{'{REQ_UPDATE, 32'd1000, 32'd0, 8'd0}, 1'b1,
              '{ST_DEGRADED, ST_DEGRADED, 32'd1000, 32'd50, 1'b1, 16'd2, 16'd4, 16'd4}},
            '{'{REQ_UPDATE, 32'd5000, 32'd0, 8'd0}, 1'b1,
              '{ST_SIM, ST_SIM, 32'd5000, 32'd0, 1'b0, 16'd2, 16'd4, 16'd4}},
            '{'{REQ_TICK, 32'd5010, 32'd7010, 8'd6}, 1'b1,
              '{ST_LOCKED, ST_SIM, 32'd7010, 32'd2000, 1'b1, 16'd2, 16'd4, 16'd5}},
            '{'{REQ_UPDATE, 32'd5100, 32'd0, 8'd0}, 1'b0, NO_RES},
            '{'{REQ_TICK, 32'd5110, 32'd2110, 8'd7}, 1'b0, NO_RES},
            '{'{REQ_TICK, 32'd5120, 32'd2130, 8'd8}, 1'b0, NO_RES},
            '{'{REQ_UPDATE, 32'd5200, 32'd0, 8'd0}, 1'b0, NO_RES},
            '{'{REQ_TICK, 32'd5210, 32'd5210 + 32'h8000_0000, 8'd9}, 1'b0, NO_RES},
            '{'{REQ_UPDATE, 32'd5300, 32'd0, 8'd0}, 1'b0, NO_RES},
            '{'{REQ_TICK, 32'd5310, 32'd5310 + 32'h7FFF_FFFF, 8'd10}, 1'b0, NO_RES},
            '{'{REQ_TICK, 32'd5320, 32'd5320 + 32'h8000_0000, 8'd11}, 1'b0, NO_RES},
            '{'{REQ_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255}, 1'b0, NO_RES},
            '{'{REQ_DATA, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255}, 1'b0, NO_RES},
            '{'{REQ_TICK, 32'd0, 32'd0, 8'd0}, 1'b0, NO_RES}
        };

        // reset the tracker copy
        cfg_basis_ms = RST_BASIS_LOST;
        cfg_degrade_ms = RST_DEGRADE;
        cfg_sim_ms = RST_SIM_FALLBACK;
        cfg_epoch_ms = RST_EPOCH_JUMP;
        cfg_gain_shift = RST_ALPHA_SHIFT;
        for (int i = 0; i < WIN_DEPTH; i++) win_samples[i] = '0;
        win_fill = 0;
        win_head = 0;
        est_offset = '0;
        est_held = 1'b0;
        link_st = ST_SIM;
        data_st = ST_SIM;
        prev_seq = '0;
        seq_seen = 1'b0;
        gap_cnt = '0;
        miss_cnt = '0;
        tick_cnt = '0;
        last_tick_ms = '0;
        last_data_ms = '0;
        now_ms = '0;
        tick_seen = 1'b0;
        data_seen = 1'b0;

        sim_local = 32'd10000;
        sim_off = $urandom;
        sim_seq = 8'($urandom_range(0, 255));
        burst_left = $urandom_range(1, 40);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_COUNT; k++)
            send_event(dir_rows[k].ev, dir_rows[k].typed, dir_rows[k].res);

        // random phases; the registers are rewritten before each phase after the first
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) begin
                wait_idle();
                apply_phase_config(p);
            end
            if (p == 3) long_hold_req = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                gen_link_event(ev);
                send_event(ev, 1'b0, NO_RES);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
